### rtl/core/qbs_pkg.sv
// ----------------------------------------------------------------------------
// qbs_pkg
// Shared constants, types and control structs of the quad batch splitter.
// ----------------------------------------------------------------------------
package qbs_pkg;

    // texture slot table size and derived widths
    localparam int MAX_SLOTS = 16;
    localparam int SLOT_W    = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam int CNT_W     = $clog2(MAX_SLOTS + 1);

    // field widths
    localparam int ID_W      = 16;
    localparam int QUAD_W    = 16;
    localparam int SIDX_W    = 4;
    localparam int BSLOT_W   = 5;
    localparam int IDX_W     = 19;

    localparam logic [QUAD_W-1:0] MAX_QUADS_RESET = 16'd20000;
    localparam logic [QUAD_W-1:0] QUADS_SAT       = 16'hFFFF;

    // request and result codes
    localparam logic REQ_DRAW    = 1'b0;
    localparam logic REQ_FLUSH   = 1'b1;
    localparam logic RES_PLACED  = 1'b0;
    localparam logic RES_EXECUTE = 1'b1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EVAL,
        S_PLACE
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic in_ready;
        logic emit_exec;
        logic exec_last;
        logic place;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic in_valid;
        logic is_flush;
        logic batch_empty;
        logic close_needed;
        logic out_free;
    } t_status;

    typedef struct packed {
        logic               result_kind;
        logic [SIDX_W-1:0]  slot_index;
        logic               slot_is_new;
        logic [ID_W-1:0]    placed_texture;
        logic [ID_W-1:0]    batch_shader;
        logic [QUAD_W-1:0]  batch_quads;
        logic [BSLOT_W-1:0] batch_slots;
        logic [IDX_W-1:0]   batch_indices;
        logic               last;
    } t_result;

endpackage

### rtl/core/qbs_if.sv
// ----------------------------------------------------------------------------
// qbs_if
// Handshake channels of the quad batch splitter: requests, results, config.
// ----------------------------------------------------------------------------
interface qbs_req_if import qbs_pkg::*; ();
    logic            valid;
    logic            ready;
    logic            req_type;
    logic [ID_W-1:0] shader_id;
    logic [ID_W-1:0] texture_id;

    modport source (output valid, req_type, shader_id, texture_id, input ready);
    modport sink   (input valid, req_type, shader_id, texture_id, output ready);
endinterface

interface qbs_res_if import qbs_pkg::*; ();
    logic               valid;
    logic               ready;
    logic               result_kind;
    logic [SIDX_W-1:0]  slot_index;
    logic               slot_is_new;
    logic [ID_W-1:0]    placed_texture;
    logic [ID_W-1:0]    batch_shader;
    logic [QUAD_W-1:0]  batch_quads;
    logic [BSLOT_W-1:0] batch_slots;
    logic [IDX_W-1:0]   batch_indices;
    logic               last;

    modport source (output valid, result_kind, slot_index, slot_is_new, placed_texture,
                    batch_shader, batch_quads, batch_slots, batch_indices, last,
                    input ready);
    modport sink   (input valid, result_kind, slot_index, slot_is_new, placed_texture,
                    batch_shader, batch_quads, batch_slots, batch_indices, last,
                    output ready);
endinterface

interface qbs_cfg_if import qbs_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [QUAD_W-1:0] max_quads;

    modport source (output valid, max_quads, input ready);
    modport sink   (input valid, max_quads, output ready);
endinterface

### rtl/core/qbs_ctrl.sv
// ----------------------------------------------------------------------------
// qbs_ctrl
// Sequencer: takes one item, evaluates it, emits a batch close and/or a
// placement into the output register, or nothing for an empty-batch flush.
// ----------------------------------------------------------------------------
module qbs_ctrl import qbs_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    t_state r_state;
    t_state n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and commands
    always_comb begin
        n_state         = r_state;
        o_cmd.in_ready  = 1'b0;
        o_cmd.emit_exec = 1'b0;
        o_cmd.exec_last = 1'b0;
        o_cmd.place     = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_cmd.in_ready = 1'b1;
                if (i_status.in_valid) begin
                    n_state = S_EVAL;
                end
            end
            S_EVAL: begin
                priority if (i_status.is_flush && i_status.batch_empty) begin
                    n_state = S_IDLE;
                end else if (!i_status.out_free) begin
                    n_state = S_EVAL;
                end else if (i_status.is_flush) begin
                    o_cmd.emit_exec = 1'b1;
                    o_cmd.exec_last = 1'b1;
                    n_state         = S_IDLE;
                end else if (i_status.close_needed) begin
                    o_cmd.emit_exec = 1'b1;
                    n_state         = S_PLACE;
                end else begin
                    o_cmd.place = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            S_PLACE: begin
                if (i_status.out_free) begin
                    o_cmd.place = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

### rtl/core/qbs_datapath.sv
// ----------------------------------------------------------------------------
// qbs_datapath
// Input register, slot table with parallel compare, batch counters,
// max_quads register and the output register.
// ----------------------------------------------------------------------------
module qbs_datapath import qbs_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_cmd          i_cmd,
    output t_status       o_status,
    qbs_req_if.sink       i_req,
    qbs_res_if.source     o_res,
    qbs_cfg_if.sink       i_cfg
);

    logic              r_req_type;
    logic [ID_W-1:0]   r_shader;
    logic [ID_W-1:0]   r_texture;
    logic [QUAD_W-1:0] r_max_quads;
    logic [ID_W-1:0]   r_cur_shader;
    logic [CNT_W-1:0]  r_slots_used;
    logic [QUAD_W-1:0] r_quads;
    logic [ID_W-1:0]   r_slot_table [MAX_SLOTS];
    t_result           r_out;
    logic              r_out_valid;

    logic              hit;
    logic [SLOT_W-1:0] hit_idx;
    logic [CNT_W-1:0]  slot;
    logic              table_full;
    logic              batch_empty;
    logic [ID_W-1:0]   place_shader;
    logic              out_free;
    logic [IDX_W-1:0]  quads_ext;

    assign i_req.ready = i_cmd.in_ready;
    assign i_cfg.ready = 1'b1;

    // input item register
    always_ff @(posedge i_clk) begin
        if (i_req.valid && i_req.ready) begin
            r_req_type <= i_req.req_type;
            r_shader   <= i_req.shader_id;
            r_texture  <= i_req.texture_id;
        end
    end

    // parallel slot compare, lowest matching slot wins
    always_comb begin
        hit     = 1'b0;
        hit_idx = '0;
        for (int i = MAX_SLOTS - 1; i >= 0; i--) begin
            if ((CNT_W'(i) < r_slots_used) && (r_slot_table[i] == r_texture)) begin
                hit     = 1'b1;
                hit_idx = SLOT_W'(i);
            end
        end
    end

    assign table_full   = (r_slots_used >= CNT_W'(MAX_SLOTS));
    assign batch_empty  = (r_quads == '0);
    assign slot         = hit ? CNT_W'(hit_idx) : r_slots_used;
    assign place_shader = batch_empty ? r_shader : r_cur_shader;
    assign out_free     = !r_out_valid || o_res.ready;
    assign quads_ext    = IDX_W'(r_quads);

    // status to the controller
    always_comb begin
        o_status.in_valid     = i_req.valid;
        o_status.is_flush     = (r_req_type == REQ_FLUSH);
        o_status.batch_empty  = batch_empty;
        o_status.close_needed = !batch_empty &&
                                ((r_shader != r_cur_shader) ||
                                 (!hit && table_full) ||
                                 (r_quads >= r_max_quads));
        o_status.out_free     = out_free;
    end

    // config register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_quads <= MAX_QUADS_RESET;
        end else if (i_cfg.valid && i_cfg.ready) begin
            r_max_quads <= i_cfg.max_quads;
        end
    end

    // batch state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_shader <= '0;
            r_slots_used <= '0;
            r_quads      <= '0;
        end else if (i_cmd.emit_exec) begin
            r_slots_used <= '0;
            r_quads      <= '0;
        end else if (i_cmd.place) begin
            r_cur_shader <= place_shader;
            if (!hit && !table_full) begin
                r_slots_used <= r_slots_used + CNT_W'(1);
            end
            if (r_quads != QUADS_SAT) begin
                r_quads <= r_quads + QUAD_W'(1);
            end
        end
    end

    // slot table, no reset: only entries below the fill count are read
    always_ff @(posedge i_clk) begin
        if (i_cmd.place && !hit && !table_full) begin
            r_slot_table[r_slots_used[SLOT_W-1:0]] <= r_texture;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit_exec || i_cmd.place) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_exec) begin
            r_out.result_kind    <= RES_EXECUTE;
            r_out.slot_index     <= '0;
            r_out.slot_is_new    <= 1'b0;
            r_out.placed_texture <= '0;
            r_out.batch_shader   <= r_cur_shader;
            r_out.batch_quads    <= r_quads;
            r_out.batch_slots    <= BSLOT_W'(r_slots_used);
            r_out.batch_indices  <= (quads_ext << 2) + (quads_ext << 1);
            r_out.last           <= i_cmd.exec_last;
        end else if (i_cmd.place) begin
            r_out.result_kind    <= RES_PLACED;
            r_out.slot_index     <= SIDX_W'(slot);
            r_out.slot_is_new    <= !hit;
            r_out.placed_texture <= r_texture;
            r_out.batch_shader   <= place_shader;
            r_out.batch_quads    <= '0;
            r_out.batch_slots    <= '0;
            r_out.batch_indices  <= '0;
            r_out.last           <= 1'b1;
        end
    end

    assign o_res.valid          = r_out_valid;
    assign o_res.result_kind    = r_out.result_kind;
    assign o_res.slot_index     = r_out.slot_index;
    assign o_res.slot_is_new    = r_out.slot_is_new;
    assign o_res.placed_texture = r_out.placed_texture;
    assign o_res.batch_shader   = r_out.batch_shader;
    assign o_res.batch_quads    = r_out.batch_quads;
    assign o_res.batch_slots    = r_out.batch_slots;
    assign o_res.batch_indices  = r_out.batch_indices;
    assign o_res.last           = r_out.last;

    // checks
    a_slots_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_slots_used <= CNT_W'(MAX_SLOTS))
        else $error("slot fill count beyond table size");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.emit_exec || i_cmd.place) |-> out_free)
        else $error("result loaded while output register busy");

    a_close_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit_exec |=> (r_quads == '0) && (r_slots_used == '0))
        else $error("batch not cleared after close");

    a_placed_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.place |=> (r_quads != '0) && (r_slots_used != '0))
        else $error("placement left batch empty");

endmodule

### rtl/core/quad_batch_splitter.sv
// An accepted item is held in the input register and evaluated; its result,
// if any, goes into the output register once that register is free, and a
// draw that closes a batch gives the executed report first, then placement.
// One item at a time; a stalled sink holds the single output register.
// Reset: synchronous active low; batch empty, shader 0, max_quads 20000.
// ----------------------------------------------------------------------------
// quad_batch_splitter
// Splits quad draw commands into batches by shader, texture slots and quad
// count, reporting each placement and each executed batch.
// ----------------------------------------------------------------------------
module quad_batch_splitter import qbs_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    qbs_req_if.sink    i_req,
    qbs_res_if.source  o_res,
    qbs_cfg_if.sink    i_cfg
);

    t_cmd    cmd;
    t_status status;

    // sequencer
    qbs_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_status (status),
        .o_cmd    (cmd)
    );

    // batch datapath
    qbs_datapath u_datapath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (cmd),
        .o_status (status),
        .i_req    (i_req),
        .o_res    (o_res),
        .i_cfg    (i_cfg)
    );

endmodule

### verif/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives quad draw and flush commands into the batch splitter with random
// gaps and output stalls. A built-in predictor tracks the batch shader,
// texture slots and quad count, and every result is checked field by field
// in order. The quad limit changes between phases while the block is idle.
// ----------------------------------------------------------------------------
module testbench import qbs_pkg::*; ;
    timeunit 1ns;
    timeprecision 1ps;

    // pacing styles for gaps and stalls
    localparam int PACE_FULL   = 0;
    localparam int PACE_RANDOM = 1;
    localparam int PACE_BURSTY = 2;

    localparam int RESET_CYCLES = 12;
    localparam int SETTLE       = 6;
    localparam int QUIET_LIMIT  = 2000;
    localparam int HOLD_AT      = 300;
    localparam int HOLD_CYCLES  = 120;
    localparam int NUM_PHASES   = 8;
    localparam int PHASE_ITEMS  = 85;

    typedef enum logic [1:0] {
        STIM_REQ,
        STIM_CFG,
        STIM_DRAIN
    } t_stim_kind;

    typedef struct {
        t_stim_kind        kind;
        logic              req_type;
        logic [ID_W-1:0]   shader;
        logic [ID_W-1:0]   tex;
        logic [QUAD_W-1:0] limit;
        int                pace;
    } t_stim;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    qbs_req_if req_ch ();
    qbs_res_if res_ch ();
    qbs_cfg_if cfg_ch ();

    quad_batch_splitter uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_res   (res_ch),
        .i_cfg   (cfg_ch)
    );

    // clock
    always #10 i_clk = ~i_clk;

    // pending commands and results still owed by the block
    t_stim   stim_q[$];
    t_result results_due[$];

    // tracked batch state
    logic [QUAD_W-1:0] quad_limit  = MAX_QUADS_RESET;
    logic [ID_W-1:0]   cur_shader  = '0;
    logic [ID_W-1:0]   slot_tex [MAX_SLOTS];
    logic [CNT_W-1:0]  slots_taken = '0;
    logic [QUAD_W-1:0] quad_count  = '0;

    // handshake flags seen at the rising edge, used at the falling edge
    logic req_taken = 1'b0;
    logic cfg_taken = 1'b0;
    logic res_taken = 1'b0;
    logic feed_done = 1'b0;

    int mismatches   = 0;
    int results_seen = 0;
    int quiet_cycles = 0;
    int sender_gap   = 0;
    int settle_cnt   = 0;
    int sink_wait    = 0;
    int sink_hold    = 0;

    function automatic int draw_wait(input int pace);
        case (pace)
            PACE_FULL:   return 0;
            PACE_RANDOM: return $urandom_range(0, 9);
            default:     return ($urandom_range(0, 3) == 0) ? $urandom_range(1, 9) : 0;
        endcase
    endfunction

    // executed report of the open batch
    function automatic t_result executed_batch(input logic is_last);
        t_result r;
        r               = '0;
        r.result_kind   = RES_EXECUTE;
        r.batch_shader  = cur_shader;
        r.batch_quads   = quad_count;
        r.batch_slots   = BSLOT_W'(slots_taken);
        r.batch_indices = IDX_W'(quad_count * 6);
        r.last          = is_last;
        return r;
    endfunction

    // apply one accepted command to the batch state and queue its results
    function automatic void batch_step(input logic req, input logic [ID_W-1:0] shader,
                                       input logic [ID_W-1:0] tex);
        t_result r;
        int      slot;
        bit      hit;
        slot = 0;
        hit  = 1'b0;
        if (req == REQ_FLUSH) begin
            if (quad_count != 0) begin
                results_due.push_back(executed_batch(1'b1));
                quad_count  = '0;
                slots_taken = '0;
            end
        end else begin
            for (int i = 0; i < MAX_SLOTS; i++) begin
                if (!hit && i < slots_taken && slot_tex[i] == tex) begin
                    hit  = 1'b1;
                    slot = i;
                end
            end
            // close on shader change, full slot table or quad limit
            if (quad_count != 0 && (shader != cur_shader ||
                    (!hit && slots_taken >= MAX_SLOTS) || quad_count >= quad_limit)) begin
                results_due.push_back(executed_batch(1'b0));
                quad_count  = '0;
                slots_taken = '0;
                hit         = 1'b0;
            end
            if (quad_count == 0)
                cur_shader = shader;
            if (!hit) begin
                slot = slots_taken;
                if (slot < MAX_SLOTS) begin
                    slot_tex[slot] = tex;
                    slots_taken    = slots_taken + 1'b1;
                end
            end
            if (quad_count != QUADS_SAT)
                quad_count = quad_count + 1'b1;
            r                = '0;
            r.result_kind    = RES_PLACED;
            r.slot_index     = SIDX_W'(slot);
            r.slot_is_new    = !hit;
            r.placed_texture = tex;
            r.batch_shader   = cur_shader;
            r.last           = 1'b1;
            results_due.push_back(r);
        end
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
            mismatches++;
        end
    endtask

    function automatic void push_item(input logic rt, input logic [ID_W-1:0] sh,
                                      input logic [ID_W-1:0] tx, input int pace);
        stim_q.push_back('{STIM_REQ, rt, sh, tx, 16'd0, pace});
    endfunction

    // monitor: checks results, tracks accepted items and config writes
    always @(posedge i_clk) begin : monitor
        t_result want;
        bit      req_fire;
        bit      res_fire;
        bit      cfg_fire;
        req_fire = req_ch.valid && req_ch.ready;
        res_fire = res_ch.valid && res_ch.ready;
        cfg_fire = cfg_ch.valid && cfg_ch.ready;
        if (i_rst_n) begin
            req_taken <= req_fire;
            cfg_taken <= cfg_fire;
            res_taken <= res_fire;
            if (res_fire) begin
                results_seen++;
                if (results_due.size() == 0) begin
                    $display("%0t: result with none expected, expected none, got kind %0d",
                             $time, res_ch.result_kind);
                    mismatches++;
                end else begin
                    want = results_due.pop_front();
                    check_field("result_kind", want.result_kind, res_ch.result_kind);
                    check_field("slot_index", want.slot_index, res_ch.slot_index);
                    check_field("slot_is_new", want.slot_is_new, res_ch.slot_is_new);
                    check_field("placed_texture", want.placed_texture, res_ch.placed_texture);
                    check_field("batch_shader", want.batch_shader, res_ch.batch_shader);
                    check_field("batch_quads", want.batch_quads, res_ch.batch_quads);
                    check_field("batch_slots", want.batch_slots, res_ch.batch_slots);
                    check_field("batch_indices", want.batch_indices, res_ch.batch_indices);
                    check_field("last", want.last, res_ch.last);
                end
            end
            if (cfg_fire)
                quad_limit = cfg_ch.max_quads;
            if (req_fire)
                batch_step(req_ch.req_type, req_ch.shader_id, req_ch.texture_id);
            // watchdog on cycles with no handshake at all
            if (req_fire || res_fire || cfg_fire)
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles == QUIET_LIMIT) begin
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    // driver: feeds commands, config writes and drain pauses from the queue
    always @(negedge i_clk) begin : driver
        t_stim s;
        logic  req_v;
        logic  cfg_v;
        if (i_rst_n) begin
            req_v = req_ch.valid;
            cfg_v = cfg_ch.valid;
            if (req_taken) begin
                req_v      = 1'b0;
                sender_gap = draw_wait(s.pace);
            end
            if (cfg_taken)
                cfg_v = 1'b0;
            if (!req_v && !cfg_v) begin
                if (sender_gap > 0) begin
                    sender_gap--;
                end else if (stim_q.size() != 0) begin
                    case (stim_q[0].kind)
                        STIM_REQ: begin
                            s     = stim_q.pop_front();
                            req_v = 1'b1;
                            req_ch.req_type   <= s.req_type;
                            req_ch.shader_id  <= s.shader;
                            req_ch.texture_id <= s.tex;
                        end
                        STIM_CFG: begin
                            s     = stim_q.pop_front();
                            cfg_v = 1'b1;
                            cfg_ch.max_quads <= s.limit;
                        end
                        default: begin
                            // wait for every result, then let the block settle for idle work
                            if (results_due.size() != 0) begin
                                settle_cnt = 0;
                            end else if (settle_cnt == SETTLE) begin
                                void'(stim_q.pop_front());
                                settle_cnt = 0;
                            end else begin
                                settle_cnt++;
                            end
                        end
                    endcase
                end
            end
            req_ch.valid <= req_v;
            cfg_ch.valid <= cfg_v;
            feed_done = (stim_q.size() == 0) && !req_v && !cfg_v;
        end
    end

    // result sink: random stalls plus one long hold-off
    always @(negedge i_clk) begin : sink
        logic rdy;
        if (i_rst_n) begin
            if (res_taken) begin
                sink_wait = draw_wait((results_seen / 64) % 3);
                if (results_seen == HOLD_AT)
                    sink_hold = HOLD_CYCLES;
            end
            if (sink_hold > 0) begin
                sink_hold--;
                rdy = 1'b0;
            end else if (sink_wait > 0) begin
                sink_wait--;
                rdy = 1'b0;
            end else begin
                rdy = 1'b1;
            end
            res_ch.ready <= rdy;
        end
    end

    // stimulus and end of run
    initial begin : stimulus
        static int         phase_limit [NUM_PHASES] = '{1, 65535, 3, 2, 16, 0, 65535, 20000};
        static int         phase_sp    [NUM_PHASES] = '{2, 1, 2, 3, 1, 0, 3, 2};
        static int         phase_tp    [NUM_PHASES] = '{4, 12, 6, 20, 30, 0, 18, 17};
        static int         phase_flush [NUM_PHASES] = '{5, 0, 5, 5, 3, 5, 4, 5};
        logic [ID_W-1:0]   shader_pool [4];
        logic [ID_W-1:0]   tex_pool [40];
        logic [QUAD_W-1:0] lim;
        int                sp;
        int                tp;
        int                pick;
        int                roll;
        int                pace;

        req_ch.valid      = 1'b0;
        req_ch.req_type   = REQ_DRAW;
        req_ch.shader_id  = '0;
        req_ch.texture_id = '0;
        res_ch.ready      = 1'b0;
        cfg_ch.valid      = 1'b0;
        cfg_ch.max_quads  = '0;

        // directed: empty flush, reuse, shader change, flush, full slot table
        push_item(REQ_FLUSH, 16'h0000, 16'h0000, PACE_FULL);
        push_item(REQ_DRAW, 16'h0000, 16'h0000, PACE_FULL);
        push_item(REQ_DRAW, 16'h0000, 16'h0000, PACE_FULL);
        push_item(REQ_DRAW, 16'h0000, 16'hFFFF, PACE_FULL);
        push_item(REQ_DRAW, 16'hFFFF, 16'hFFFF, PACE_FULL);
        push_item(REQ_FLUSH, 16'hFFFF, 16'hFFFF, PACE_FULL);
        push_item(REQ_FLUSH, 16'h0000, 16'h0000, PACE_FULL);
        for (int i = 0; i <= MAX_SLOTS; i++)
            push_item(REQ_DRAW, 16'h0005, 16'(16'h1000 + i), PACE_FULL);
        push_item(REQ_FLUSH, 16'h0000, 16'h0000, PACE_FULL);

        // random phases, each starting from an idle block with a new limit
        for (int p = 0; p < NUM_PHASES; p++) begin
            lim  = (phase_limit[p] == 0) ? 16'($urandom_range(1, 40)) : 16'(phase_limit[p]);
            sp   = (phase_sp[p] == 0) ? $urandom_range(1, 4) : phase_sp[p];
            tp   = (phase_tp[p] == 0) ? $urandom_range(1, 40) : phase_tp[p];
            pace = p % 3;
            foreach (shader_pool[i])
                shader_pool[i] = 16'($urandom);
            foreach (tex_pool[i])
                tex_pool[i] = 16'($urandom);
            stim_q.push_back('{STIM_DRAIN, 1'b0, 16'd0, 16'd0, 16'd0, PACE_FULL});
            stim_q.push_back('{STIM_CFG, 1'b0, 16'd0, 16'd0, lim, PACE_FULL});
            pick = 0;
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                roll = $urandom_range(0, 99);
                if ($urandom_range(0, 9) == 0)
                    pick = $urandom_range(0, sp - 1);
                if (roll < phase_flush[p])
                    push_item(REQ_FLUSH, 16'($urandom), 16'($urandom), pace);
                else if (roll < phase_flush[p] + 10)
                    push_item(REQ_DRAW, 16'($urandom), 16'($urandom), pace);
                else
                    push_item(REQ_DRAW, shader_pool[pick],
                              tex_pool[$urandom_range(0, tp - 1)], pace);
            end
        end

        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        wait (feed_done);
        wait (results_due.size() == 0);
        repeat (SETTLE * 4) @(posedge i_clk);
        if (mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

### sim.f
rtl/core/qbs_pkg.sv
rtl/core/qbs_if.sv
rtl/core/qbs_ctrl.sv
rtl/core/qbs_datapath.sv
rtl/core/quad_batch_splitter.sv
verif/testbench.sv
